@@ hdl/rc_pulse_to_control_mapper_assert.svh @@
// Assertion macros for the checker file of the mapper.
`ifndef RC_PULSE_TO_CONTROL_MAPPER_ASSERT_SVH
`define RC_PULSE_TO_CONTROL_MAPPER_ASSERT_SVH

// Check that cons holds in the cycle in which ante holds.
`define RCPM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cond never holds.
`define RCPM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

@@ hdl/rcpm_pkg.sv @@
package rcpm_pkg;

    // Fixed field widths
    localparam int IN_W       = 16;
    localparam int OUT_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DB_W       = 10;
    localparam int MODE_W     = 2;
    // Signed factor and offset width (difference of two 16-bit signed values)
    localparam int FAC_W      = 17;
    localparam int OFS_W      = 17;
    localparam int Q14_ONE    = 16384;
    // Pipeline stages outside the divider chain: operand, product, output
    localparam int PIPE_EXTRA = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_RANGE   = 2'd0,
        MODE_ANGLE   = 2'd1,
        MODE_PERCENT = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE       = 3'd0,
        REG_PULSE_MIN  = 3'd1,
        REG_PULSE_MAX  = 3'd2,
        REG_PULSE_MID  = 3'd3,
        REG_DEAD_BAND  = 3'd4,
        REG_REVERSE_ON = 3'd5,
        REG_OUT_MIN    = 3'd6,
        REG_OUT_MAX    = 3'd7
    } t_reg_idx;

    // Per-word side data that travels along the divider chain
    typedef struct packed {
        logic                    qneg;
        logic                    rneg;
        logic                    fault;
        logic signed [OFS_W-1:0] offset;
    } t_side;

    // Bits that bound both pulse values and the dead band
    function automatic int span_w(input int pulse_bits);
        return (pulse_bits > DB_W) ? pulse_bits : DB_W;
    endfunction

endpackage

@@ hdl/rcpm_front.sv @@
module rcpm_front import rcpm_pkg::*; #(
    parameter  int PULSE_BITS = 12,
    localparam int MW         = span_w(PULSE_BITS),
    localparam int SW         = MW + 3,
    localparam int DW         = MW + 1,
    localparam int NW         = MW + FAC_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [IN_W-1:0]       i_pulse_width,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [PULSE_BITS-1:0] i_pulse_min,
    input  logic [PULSE_BITS-1:0] i_pulse_max,
    input  logic [PULSE_BITS-1:0] i_pulse_mid,
    input  logic [DB_W-1:0]       i_dead_band,
    input  logic                  i_reverse_on,
    input  logic signed [15:0]    i_out_min,
    input  logic signed [15:0]    i_out_max,
    output logic                  o_valid,
    output logic [NW-1:0]         o_num,
    output logic [DW-1:0]         o_dvs,
    output t_side                 o_side
);

    localparam int PW = FAC_W + SW;

    logic [PULSE_BITS-1:0]   s_r;
    logic signed [SW-1:0]    s_rs, s_lo, s_hi, s_mid, s_db;
    logic signed [SW-1:0]    s_rr, s_floor, s_th, s_tl, s_dlo, s_dhi;
    logic signed [FAC_W-1:0] s_span, s_omax;
    logic signed [OFS_W-1:0] s_omin;
    logic signed [FAC_W-1:0] s_a;
    logic signed [SW-1:0]    s_b, s_d;
    t_side                   s_side;

    logic                    r1_valid;
    logic signed [FAC_W-1:0] r1_a;
    logic signed [SW-1:0]    r1_b, r1_d;
    t_side                   r1_side;

    logic signed [PW-1:0]    s_prod;
    logic [PW-1:0]           s_pmag;
    logic [SW-1:0]           s_dmag;
    t_side                   s_side2;

    // Clamp the pulse to the configured limits, floor first
    always_comb begin
        if (i_pulse_width < IN_W'(i_pulse_min)) begin
            s_r = i_pulse_min;
        end else if (i_pulse_width > IN_W'(i_pulse_max)) begin
            s_r = i_pulse_max;
        end else begin
            s_r = i_pulse_width[PULSE_BITS-1:0];
        end
    end

    // Widen to signed working values
    assign s_rs    = SW'(s_r);
    assign s_lo    = SW'(i_pulse_min);
    assign s_hi    = SW'(i_pulse_max);
    assign s_mid   = SW'(i_pulse_mid);
    assign s_db    = SW'(i_dead_band);
    assign s_rr    = i_reverse_on ? (s_hi + s_lo - s_rs) : s_rs;
    assign s_floor = s_lo + s_db;
    assign s_th    = s_mid + s_db;
    assign s_tl    = s_mid - s_db;
    assign s_dlo   = s_tl - s_lo;
    assign s_dhi   = s_hi - s_th;
    assign s_span  = FAC_W'(i_out_max) - FAC_W'(i_out_min);
    assign s_omax  = FAC_W'(i_out_max);
    assign s_omin  = OFS_W'(i_out_min);

    // Select factor, difference and divisor by mode; no division gives 0 / 1
    always_comb begin
        s_a    = '0;
        s_b    = '0;
        s_d    = SW'(1);
        s_side = '0;
        unique case (t_mode'(i_mode))
            MODE_RANGE: begin
                if (s_rr > s_floor) begin
                    if (s_hi == s_floor) begin
                        s_side.fault = 1'b1;
                    end else begin
                        s_a           = s_span;
                        s_b           = s_rr - s_floor;
                        s_d           = s_hi - s_floor;
                        s_side.offset = s_omin;
                    end
                end else if (i_dead_band == '0) begin
                    s_side.offset = s_omin;
                end
            end
            MODE_ANGLE: begin
                s_side.rneg = i_reverse_on;
                if (s_dlo == '0 || s_dhi == '0) begin
                    s_side.fault = 1'b1;
                end else if (s_rs > s_th) begin
                    s_a = s_omax;
                    s_b = s_rs - s_th;
                    s_d = s_dhi;
                end else if (s_rs < s_tl) begin
                    s_a = s_omax;
                    s_b = s_rs - s_tl;
                    s_d = s_dlo;
                end
            end
            MODE_PERCENT: begin
                if (s_hi == s_lo) begin
                    s_side.fault = 1'b1;
                end else begin
                    s_a = FAC_W'(Q14_ONE);
                    s_b = s_rr - s_lo;
                    s_d = s_hi - s_lo;
                end
            end
            default: begin
            end
        endcase
    end

    // Operand stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
        r1_a    <= s_a;
        r1_b    <= s_b;
        r1_d    <= s_d;
        r1_side <= s_side;
    end

    // Multiply and split into sign and magnitudes
    assign s_prod = PW'(r1_a) * PW'(r1_b);
    assign s_pmag = s_prod[PW-1] ? PW'(-s_prod) : PW'(s_prod);
    assign s_dmag = r1_d[SW-1] ? SW'(-r1_d) : SW'(r1_d);

    always_comb begin
        s_side2      = r1_side;
        s_side2.qneg = s_prod[PW-1] ^ r1_d[SW-1];
    end

    // Product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r1_valid;
        end
        o_num  <= s_pmag[NW-1:0];
        o_dvs  <= s_dmag[DW-1:0];
        o_side <= s_side2;
    end

endmodule

@@ hdl/rcpm_div_cell.sv @@
module rcpm_div_cell import rcpm_pkg::*; #(
    parameter int NW = 29,
    parameter int DW = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_dvs,
    input  t_side         i_side,
    output logic          o_valid,
    output logic [DW-1:0] o_rem,
    output logic [NW-1:0] o_num,
    output logic [DW-1:0] o_dvs,
    output t_side         o_side
);

    logic [DW:0]   s_shift;
    logic [DW+1:0] s_diff;
    logic          s_ge;

    // Bring down the next dividend bit and try a subtract
    assign s_shift = {i_rem, i_num[NW-1]};
    assign s_diff  = {1'b0, s_shift} - {2'b00, i_dvs};
    assign s_ge    = !s_diff[DW+1];

    // Hand the word to the next cell, quotient bit shifted in at the bottom
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
        o_rem  <= s_ge ? s_diff[DW-1:0] : s_shift[DW-1:0];
        o_num  <= {i_num[NW-2:0], s_ge};
        o_dvs  <= i_dvs;
        o_side <= i_side;
    end

endmodule

@@ hdl/rcpm_back.sv @@
module rcpm_back import rcpm_pkg::*; #(
    parameter  int PULSE_BITS = 12,
    localparam int NW         = span_w(PULSE_BITS) + FAC_W
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [NW-1:0]           i_q,
    input  t_side                   i_side,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_control_value,
    output logic                    o_divide_fault
);

    localparam logic signed [NW+2:0] SAT_HI = (NW+3)'(32767);
    localparam logic signed [NW+2:0] SAT_LO = (NW+3)'(-32768);

    logic signed [NW:0]   s_sq;
    logic signed [NW+1:0] s_sum;
    logic signed [NW+2:0] s_ext, s_neg;
    logic signed [OUT_W-1:0] s_val;

    // Apply quotient sign, add offset, negate for reversed angle
    assign s_sq  = i_side.qneg ? -$signed({1'b0, i_q}) : $signed({1'b0, i_q});
    assign s_sum = (NW+2)'(s_sq) + (NW+2)'($signed(i_side.offset));
    assign s_ext = (NW+3)'(s_sum);
    assign s_neg = i_side.rneg ? -s_ext : s_ext;

    // Force zero on fault, otherwise saturate to 16 bits
    always_comb begin
        if (i_side.fault) begin
            s_val = '0;
        end else if (s_neg > SAT_HI) begin
            s_val = SAT_HI[OUT_W-1:0];
        end else if (s_neg < SAT_LO) begin
            s_val = SAT_LO[OUT_W-1:0];
        end else begin
            s_val = s_neg[OUT_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
        o_control_value <= s_val;
        o_divide_fault  <= i_side.fault;
    end

endmodule

@@ hdl/rc_pulse_to_control_mapper.sv @@
// Results pass the operand and product registers, the chain of one-bit divider cells
// and the output register before the o_valid strobe.
// Throughput: one word per cycle; o_busy stays low and results flow out unstalled.
// Reset (i_rst_n low at a clock edge) restores the configuration registers to their
// defaults and clears the valid flags, dropping every word in flight.
module rc_pulse_to_control_mapper import rcpm_pkg::*; #(
    parameter int PULSE_BITS = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  logic [IN_W-1:0]         i_pulse_width,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_control_value,
    output logic                    o_divide_fault,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int MW = span_w(PULSE_BITS);
    localparam int DW = MW + 1;
    localparam int NW = MW + FAC_W;

    localparam logic [PULSE_BITS-1:0] RST_PMIN = PULSE_BITS'(1100);
    localparam logic [PULSE_BITS-1:0] RST_PMAX = PULSE_BITS'(1900);
    localparam logic [PULSE_BITS-1:0] RST_PMID = PULSE_BITS'(1500);

    logic [MODE_W-1:0]     r_mode;
    logic [PULSE_BITS-1:0] r_pulse_min, r_pulse_max, r_pulse_mid;
    logic [DB_W-1:0]       r_dead_band;
    logic                  r_reverse_on;
    logic signed [15:0]    r_out_min, r_out_max;

    logic          c_valid [0:NW];
    logic [DW-1:0] c_rem   [0:NW];
    logic [NW-1:0] c_num   [0:NW];
    logic [DW-1:0] c_dvs   [0:NW];
    t_side         c_side  [0:NW];

    // The pipeline takes a word every cycle
    assign o_busy = 1'b0;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_RANGE;
            r_pulse_min  <= RST_PMIN;
            r_pulse_max  <= RST_PMAX;
            r_pulse_mid  <= RST_PMID;
            r_dead_band  <= '0;
            r_reverse_on <= 1'b0;
            r_out_min    <= 16'sd0;
            r_out_max    <= 16'sd1000;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_MODE:       r_mode       <= i_cfg_data[MODE_W-1:0];
                REG_PULSE_MIN:  r_pulse_min  <= i_cfg_data[PULSE_BITS-1:0];
                REG_PULSE_MAX:  r_pulse_max  <= i_cfg_data[PULSE_BITS-1:0];
                REG_PULSE_MID:  r_pulse_mid  <= i_cfg_data[PULSE_BITS-1:0];
                REG_DEAD_BAND:  r_dead_band  <= i_cfg_data[DB_W-1:0];
                REG_REVERSE_ON: r_reverse_on <= i_cfg_data[0];
                REG_OUT_MIN:    r_out_min    <= $signed(i_cfg_data[15:0]);
                REG_OUT_MAX:    r_out_max    <= $signed(i_cfg_data[15:0]);
            endcase
        end
    end

    // Clamp, operand select and multiply
    rcpm_front #(.PULSE_BITS(PULSE_BITS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_start && !o_busy),
        .i_pulse_width (i_pulse_width),
        .i_mode        (r_mode),
        .i_pulse_min   (r_pulse_min),
        .i_pulse_max   (r_pulse_max),
        .i_pulse_mid   (r_pulse_mid),
        .i_dead_band   (r_dead_band),
        .i_reverse_on  (r_reverse_on),
        .i_out_min     (r_out_min),
        .i_out_max     (r_out_max),
        .o_valid       (c_valid[0]),
        .o_num         (c_num[0]),
        .o_dvs         (c_dvs[0]),
        .o_side        (c_side[0])
    );

    assign c_rem[0] = '0;

    // Divider chain: one quotient bit per cell
    for (genvar g = 0; g < NW; g++) begin : g_cell
        rcpm_div_cell #(.NW(NW), .DW(DW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[g]),
            .i_rem   (c_rem[g]),
            .i_num   (c_num[g]),
            .i_dvs   (c_dvs[g]),
            .i_side  (c_side[g]),
            .o_valid (c_valid[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_num   (c_num[g+1]),
            .o_dvs   (c_dvs[g+1]),
            .o_side  (c_side[g+1])
        );
    end

    // Sign, offset and saturation
    rcpm_back #(.PULSE_BITS(PULSE_BITS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (c_valid[NW]),
        .i_q             (c_num[NW]),
        .i_side          (c_side[NW]),
        .o_valid         (o_valid),
        .o_control_value (o_control_value),
        .o_divide_fault  (o_divide_fault)
    );

endmodule

@@ hdl/rcpm_checker.sv @@
`include "rc_pulse_to_control_mapper_assert.svh"

module rcpm_checker import rcpm_pkg::*; #(
    parameter int PULSE_BITS = 12
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_start,
    input logic                    o_busy,
    input logic                    o_valid,
    input logic signed [OUT_W-1:0] o_control_value,
    input logic                    o_divide_fault
);

    localparam int LAT = span_w(PULSE_BITS) + FAC_W + PIPE_EXTRA;

    // Every strobe answers a word taken a fixed latency earlier
    `RCPM_ASSERT_IMP(a_strobe_from_start, i_clk, i_rst_n, o_valid, $past(i_start && !o_busy, LAT), "result strobe without matching start")

    // A faulted word carries a zero value
    `RCPM_ASSERT_NEVER(a_fault_zero, i_clk, i_rst_n, o_valid && o_divide_fault && o_control_value != '0, "divide fault with nonzero value")

    // Reset flushes the pipeline
    `RCPM_ASSERT_IMP(a_reset_flush, i_clk, i_rst_n, !$past(i_rst_n), !o_valid, "result strobe right after reset")

endmodule

bind rc_pulse_to_control_mapper rcpm_checker #(.PULSE_BITS(PULSE_BITS)) u_rcpm_checker (.*);
